// ===== sv/assert_macros.svh =====
// assertion macros for the interface adapter
// used by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds after reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication on the next clock
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/via_pkg.sv =====
// package for the interface adapter: operation codes, register offsets, flags
// no dependencies
package via_pkg;
  typedef enum logic [3:0] {
    OP_READ = 4'd0, OP_WRITE = 4'd1, OP_PA = 4'd2, OP_PB = 4'd3,
    OP_CA1 = 4'd4, OP_CA2 = 4'd5, OP_CB1 = 4'd6, OP_CB2 = 4'd7, OP_TICK = 4'd8
  } via_op_t;
  typedef enum logic [3:0] {
    R_ORB = 4'd0, R_ORA = 4'd1, R_DDRB = 4'd2, R_DDRA = 4'd3,
    R_T1CL = 4'd4, R_T1CH = 4'd5, R_T1LL = 4'd6, R_T1LH = 4'd7,
    R_T2CL = 4'd8, R_T2CH = 4'd9, R_SR = 4'd10, R_ACR = 4'd11,
    R_PCR = 4'd12, R_IFR = 4'd13, R_IER = 4'd14, R_ORA_NH = 4'd15
  } via_reg_t;
  localparam logic [7:0] F_CA2 = 8'h01;
  localparam logic [7:0] F_CA1 = 8'h02;
  localparam logic [7:0] F_SR  = 8'h04;
  localparam logic [7:0] F_CB2 = 8'h08;
  localparam logic [7:0] F_CB1 = 8'h10;
  localparam logic [7:0] F_T2  = 8'h20;
  localparam logic [7:0] F_T1  = 8'h40;
  localparam logic [4:0] SR_OFF = 5'h00, SR_IN_T2 = 5'h04, SR_IN_PHI = 5'h08,
    SR_IN_CB1 = 5'h0c, SR_OUT_FREE = 5'h10, SR_OUT_T2 = 5'h14,
    SR_OUT_PHI = 5'h18, SR_OUT_CB1 = 5'h1c;
  localparam logic [15:0] T1_LATCH_RST = 16'hb5f3;
  localparam logic [15:0] T2_LATCH_RST = 16'hffff;
  localparam int FLAG_DELAY_DEF = 3;
endpackage

// ===== sv/versatile_interface_adapter_unit.sv =====
// top level of the interface adapter: registers, timers, shifter, handshake
// depends on via_pkg and assert_macros.svh
//
// Usage: one request on the in_ channel is a bus read, a bus write, a pin or
// control line change, or one bus clock tick. Every request gives exactly one
// result on the out_ channel: the read data and the levels of the port,
// control and interrupt outputs after the request took effect.
// out_valid rises in the cycle after acceptance. Throughput is one
// request per cycle: all the work of a request is one pass of logic from the
// state registers into the result register, and a new request is taken
// whenever the result register is empty or being emptied in that cycle.
// When the receiver stalls, the result is held and in_ready drops until it is
// taken; state does not change meanwhile.
// Reset (rst_n low, synchronous) puts every register at its power-up value:
// ports and control registers zero, control outputs high, timer 1 latch
// 0xb5f3, timer 2 latch 0xffff, no result pending.
// Timer counters are 17 bits so that a restart at latch plus the flag delay
// is kept exactly.
`include "assert_macros.svh"
module versatile_interface_adapter_unit
  import via_pkg::*;
#(
  parameter int FLAG_DELAY = FLAG_DELAY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_operation,
  input  logic [3:0] in_reg_select,
  input  logic [7:0] in_data_value,
  input  logic [7:0] in_pin_mask,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [7:0] out_port_a_drive,
  output logic [7:0] out_port_b_drive,
  output logic       out_ca2_level,
  output logic       out_cb1_level,
  output logic       out_cb2_level,
  output logic       out_irq_level
);
  localparam logic [16:0] FD = 17'(FLAG_DELAY);

  logic [7:0] pa_out_r, pa_dir_r, pa_lat_r, pa_pin_r;
  logic [7:0] pb_out_r, pb_dir_r, pb_lat_r, pb_pin_r;
  logic [3:0] cin_r;
  logic [2:0] cout_r;
  logic [15:0] t1_lat_r, t2_lat_r, t2_start_r;
  logic [16:0] t1_cnt_r, t2_cnt_r;
  logic t1_run_r, t1_pb7_r, t2_run_r;
  logic [7:0] sr_r;
  logic [2:0] sc_r;
  logic [9:0] st_r;
  logic ca2p_r;
  logic [7:0] pcr_r, acr_r, ifr_r;
  logic [6:0] ier_r;

  logic [7:0] pa_out_nxt, pa_dir_nxt, pa_lat_nxt, pa_pin_nxt;
  logic [7:0] pb_out_nxt, pb_dir_nxt, pb_lat_nxt, pb_pin_nxt;
  logic [3:0] cin_nxt;
  logic [2:0] cout_nxt;
  logic [15:0] t1_lat_nxt, t2_lat_nxt, t2_start_nxt;
  logic [16:0] t1_cnt_nxt, t2_cnt_nxt;
  logic t1_run_nxt, t1_pb7_nxt, t2_run_nxt;
  logic [7:0] sr_nxt;
  logic [2:0] sc_nxt;
  logic [9:0] st_nxt;
  logic ca2p_nxt;
  logic [7:0] pcr_nxt, acr_nxt, ifr_nxt;
  logic [6:0] ier_nxt;
  logic [7:0] rd_nxt;

  logic accept;
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  // combinational helpers on the present state
  logic [4:0] srm;
  logic [9:0] t2_per;
  logic [7:0] pa_in, pb_in, pb_mix, pb_drv;
  logic [15:0] cnt1, cnt2;
  logic ca2_hs, ca2_pul, cb2_hs;
  logic [7:0] pa_clr, pb_clr;
  logic lvl, changed;
  assign srm = acr_r[4:0] & 5'h1c;
  assign t2_per = {1'b0, ({1'b0, t2_lat_r[7:0]} + 9'd2)} << 1;
  assign pa_in = pa_pin_r & (pa_out_r | ~pa_dir_r);
  assign pb_mix = (pb_out_r & pb_dir_r) | (pb_pin_r & ~pb_dir_r);
  assign pb_in = acr_r[7] ? {t1_pb7_r, pb_mix[6:0]} : pb_mix;
  assign cnt1 = t1_run_r ? 16'(t1_cnt_r - FD) : t1_cnt_r[15:0];
  assign cnt2 = t2_run_r ? t2_cnt_r[15:0] : (acr_r[5] ? t2_start_r : t2_cnt_r[15:0]);
  assign ca2_hs = (pcr_r[3:2] == 2'b10);
  assign ca2_pul = (pcr_r[3:1] == 3'b101);
  assign cb2_hs = (pcr_r[7:6] == 2'b10);
  assign pa_clr = F_CA1 | (((pcr_r & 8'h0a) == 8'h02) ? 8'h00 : F_CA2);
  assign pb_clr = F_CB1 | (((pcr_r & 8'ha0) == 8'h20) ? 8'h00 : F_CB2);
  assign lvl = |(in_data_value & in_pin_mask);
  assign changed = cin_r[in_operation[1:0]] != lvl;

  // next state for one request
  always_comb begin
    logic [7:0] fl;
    logic b;
    pa_out_nxt = pa_out_r; pa_dir_nxt = pa_dir_r; pa_lat_nxt = pa_lat_r;
    pa_pin_nxt = pa_pin_r; pb_out_nxt = pb_out_r; pb_dir_nxt = pb_dir_r;
    pb_lat_nxt = pb_lat_r; pb_pin_nxt = pb_pin_r; cin_nxt = cin_r;
    cout_nxt = cout_r; t1_lat_nxt = t1_lat_r; t2_lat_nxt = t2_lat_r;
    t2_start_nxt = t2_start_r; t1_cnt_nxt = t1_cnt_r; t2_cnt_nxt = t2_cnt_r;
    t1_run_nxt = t1_run_r; t1_pb7_nxt = t1_pb7_r; t2_run_nxt = t2_run_r;
    sr_nxt = sr_r; sc_nxt = sc_r; st_nxt = st_r; ca2p_nxt = ca2p_r;
    pcr_nxt = pcr_r; acr_nxt = acr_r; ier_nxt = ier_r;
    fl = ifr_r; rd_nxt = 8'h00; b = 1'b0;
    case (in_operation)
      OP_READ: begin
        case (in_reg_select)
          R_ORB: begin
            rd_nxt = acr_r[1] ? pb_lat_r : pb_in; fl = fl & ~pb_clr;
          end
          R_ORA: begin
            rd_nxt = acr_r[0] ? pa_lat_r : pa_in; fl = fl & ~pa_clr;
            if (cout_r[0] && (ca2_pul || ca2_hs)) cout_nxt[0] = 1'b0;
            if (ca2_pul) ca2p_nxt = 1'b1;
          end
          R_DDRB: rd_nxt = pb_dir_r;
          R_DDRA: rd_nxt = pa_dir_r;
          R_T1CL: begin fl = fl & ~F_T1; rd_nxt = cnt1[7:0]; end
          R_T1CH: rd_nxt = cnt1[15:8];
          R_T1LL: rd_nxt = t1_lat_r[7:0];
          R_T1LH: rd_nxt = t1_lat_r[15:8];
          R_T2CL: begin fl = fl & ~F_T2; rd_nxt = cnt2[7:0]; end
          R_T2CH: rd_nxt = cnt2[15:8];
          R_SR: begin
            rd_nxt = sr_r; sc_nxt = '0; fl = fl & ~F_SR;
            if (srm == SR_IN_PHI) st_nxt = 10'd2;
            if (srm == SR_IN_T2) st_nxt = t2_per;
          end
          R_ACR: rd_nxt = acr_r;
          R_PCR: rd_nxt = pcr_r;
          R_IFR: rd_nxt = ifr_r;
          R_IER: rd_nxt = {1'b1, ier_r};
          default: rd_nxt = acr_r[0] ? pa_lat_r : pa_in;
        endcase
      end
      OP_WRITE: begin
        case (in_reg_select)
          R_ORB: begin
            pb_out_nxt = in_data_value; fl = fl & ~pb_clr;
            if (cout_r[2] && cb2_hs) cout_nxt[2] = 1'b0;
          end
          R_ORA: begin
            pa_out_nxt = in_data_value; fl = fl & ~pa_clr;
            if (cout_r[0] && (ca2_pul || ca2_hs)) cout_nxt[0] = 1'b0;
            if (ca2_pul) ca2p_nxt = 1'b1;
          end
          R_DDRB: pb_dir_nxt = in_data_value;
          R_DDRA: pa_dir_nxt = in_data_value;
          R_T1CL, R_T1LL: t1_lat_nxt[7:0] = in_data_value;
          R_T1LH: begin t1_lat_nxt[15:8] = in_data_value; fl = fl & ~F_T1; end
          R_T1CH: begin
            t1_lat_nxt[15:8] = in_data_value; fl = fl & ~F_T1; t1_pb7_nxt = 1'b0;
            t1_cnt_nxt = {1'b0, in_data_value, t1_lat_r[7:0]} + FD;
            t1_run_nxt = 1'b1;
          end
          R_T2CL: t2_lat_nxt[7:0] = in_data_value;
          R_T2CH: begin
            t2_lat_nxt[15:8] = in_data_value;
            t2_start_nxt = {in_data_value, t2_lat_r[7:0]};
            fl = fl & ~F_T2;
            t2_cnt_nxt = {1'b0, in_data_value, t2_lat_r[7:0]} + (acr_r[5] ? 17'd0 : FD);
            t2_run_nxt = 1'b1;
          end
          R_SR: begin
            sr_nxt = in_data_value; sc_nxt = '0; fl = fl & ~F_SR;
            if (srm == SR_OUT_PHI) st_nxt = 10'd2;
            if (srm == SR_OUT_FREE || srm == SR_OUT_T2) st_nxt = t2_per;
          end
          R_ACR: begin
            acr_nxt = in_data_value;
            if (in_data_value[6]) begin
              t1_cnt_nxt = {1'b0, cnt1} + FD; t1_run_nxt = 1'b1;
            end
          end
          R_PCR: begin
            pcr_nxt = in_data_value;
            if (in_data_value[3:2] == 2'b11) cout_nxt[0] = in_data_value[1];
            if (in_data_value[7:6] == 2'b11) cout_nxt[2] = in_data_value[5];
          end
          R_IFR: fl = fl & ~(in_data_value[7] ? 8'h7f : in_data_value);
          R_IER: begin
            if (in_data_value[7]) ier_nxt = ier_r | in_data_value[6:0];
            else ier_nxt = ier_r & ~in_data_value[6:0];
          end
          default: pa_out_nxt = in_data_value;
        endcase
      end
      OP_PA: pa_pin_nxt = (pa_pin_r & ~in_pin_mask) | (in_data_value & in_pin_mask);
      OP_PB: pb_pin_nxt = (pb_pin_r & ~in_pin_mask) | (in_data_value & in_pin_mask);
      OP_CA1, OP_CA2, OP_CB1, OP_CB2: begin
        if (changed) begin
          cin_nxt[in_operation[1:0]] = lvl;
          case (in_operation)
            OP_CA1: if (lvl == pcr_r[0]) begin
              if (acr_r[0]) pa_lat_nxt = pa_in;
              fl = fl | F_CA1;
              if (!cout_r[0] && ca2_hs) cout_nxt[0] = 1'b1;
            end
            OP_CA2: if (!pcr_r[3] && lvl == pcr_r[2]) fl = fl | F_CA2;
            OP_CB1: if (lvl == pcr_r[4]) begin
              if (acr_r[1]) pb_lat_nxt = pb_in;
              // shift on cb1 edge, out uses old data msb, in uses cb2 input
              if (srm == SR_OUT_CB1) begin
                cout_nxt[2] = sr_r[7]; sr_nxt = {sr_r[6:0], sr_r[7]};
                sc_nxt = sc_r + 3'd1;
                if (sc_r == 3'd7) fl = fl | F_SR;
              end
              if (srm == SR_IN_CB1) begin
                sr_nxt = {sr_r[6:0], cin_r[3]}; sc_nxt = sc_r + 3'd1;
                if (sc_r == 3'd7) fl = fl | F_SR;
              end
              fl = fl | F_CB1;
              if (!cout_nxt[2] && cb2_hs) cout_nxt[2] = 1'b1;
            end
            default: if (!pcr_r[7] && lvl == pcr_r[6]) fl = fl | F_CB2;
          endcase
        end
      end
      OP_TICK: begin
        // timer 1
        if (t1_run_r) begin
          if (t1_cnt_r <= 17'd1) begin
            if (acr_r[6]) begin
              t1_pb7_nxt = ~t1_pb7_r; t1_cnt_nxt = {1'b0, t1_lat_r} + FD;
            end else begin
              t1_pb7_nxt = 1'b1; t1_run_nxt = 1'b0; t1_cnt_nxt = 17'h0ffff;
            end
            fl = fl | F_T1;
          end else begin
            t1_cnt_nxt = t1_cnt_r - 17'd1;
          end
        end else begin
          t1_cnt_nxt = {1'b0, t1_cnt_r[15:0] - 16'd1};
        end
        // timer 2
        if (t2_run_r) begin
          if (t2_cnt_r <= 17'd1) begin
            t2_run_nxt = 1'b0; t2_cnt_nxt = 17'h0ffff; fl = fl | F_T2;
          end else begin
            t2_cnt_nxt = t2_cnt_r - 17'd1;
          end
        end else begin
          t2_cnt_nxt = {1'b0, t2_cnt_r[15:0] - 16'd1};
        end
        // shift clock
        if (st_r != '0) begin
          st_nxt = st_r - 10'd1;
          if (st_r == 10'd1) begin
            b = 1'b0;
            sc_nxt = sc_r;
            if (srm == SR_OUT_FREE || srm == SR_OUT_T2 || srm == SR_OUT_PHI) begin
              cout_nxt[2] = sr_r[7]; sr_nxt = {sr_r[6:0], sr_r[7]};
              b = (srm != SR_OUT_FREE);
            end
            if (srm == SR_IN_T2 || srm == SR_IN_PHI) begin
              sr_nxt = {sr_r[6:0], cin_r[3]}; b = 1'b1;
            end
            if (b) begin
              sc_nxt = sc_r + 3'd1;
              if (sc_r == 3'd7) fl = fl | F_SR;
            end
            if (srm == SR_OUT_FREE || sc_nxt != '0) begin
              if (srm == SR_IN_PHI || srm == SR_OUT_PHI) st_nxt = 10'd2;
              else st_nxt = t2_per;
            end
          end
        end
        // ca2 pulse end
        if (ca2p_r) begin ca2p_nxt = 1'b0; cout_nxt[0] = 1'b1; end
      end
      default: ;
    endcase
    ifr_nxt = {|(ier_nxt & fl[6:0]), fl[6:0]};
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_out_r <= '0; pa_dir_r <= '0; pa_lat_r <= '0; pa_pin_r <= '0;
      pb_out_r <= '0; pb_dir_r <= '0; pb_lat_r <= '0; pb_pin_r <= '0;
      cin_r <= '0; cout_r <= 3'b111;
      t1_lat_r <= T1_LATCH_RST; t2_lat_r <= T2_LATCH_RST; t2_start_r <= '0;
      t1_cnt_r <= '0; t2_cnt_r <= '0; t1_run_r <= 1'b0; t1_pb7_r <= 1'b1;
      t2_run_r <= 1'b0; sr_r <= '0; sc_r <= '0; st_r <= '0; ca2p_r <= 1'b0;
      pcr_r <= '0; acr_r <= '0; ier_r <= '0; ifr_r <= '0;
      out_valid <= 1'b0; out_read_data <= '0;
    end else begin
      if (accept) begin
        pa_out_r <= pa_out_nxt; pa_dir_r <= pa_dir_nxt; pa_lat_r <= pa_lat_nxt;
        pa_pin_r <= pa_pin_nxt; pb_out_r <= pb_out_nxt; pb_dir_r <= pb_dir_nxt;
        pb_lat_r <= pb_lat_nxt; pb_pin_r <= pb_pin_nxt; cin_r <= cin_nxt;
        cout_r <= cout_nxt; t1_lat_r <= t1_lat_nxt; t2_lat_r <= t2_lat_nxt;
        t2_start_r <= t2_start_nxt; t1_cnt_r <= t1_cnt_nxt; t2_cnt_r <= t2_cnt_nxt;
        t1_run_r <= t1_run_nxt; t1_pb7_r <= t1_pb7_nxt; t2_run_r <= t2_run_nxt;
        sr_r <= sr_nxt; sc_r <= sc_nxt; st_r <= st_nxt; ca2p_r <= ca2p_nxt;
        pcr_r <= pcr_nxt; acr_r <= acr_nxt; ier_r <= ier_nxt; ifr_r <= ifr_nxt;
        out_valid <= 1'b1; out_read_data <= rd_nxt;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result outputs follow the state registers
  assign out_port_a_drive = (pa_out_r & pa_dir_r) | ~pa_dir_r;
  assign pb_drv = (pb_out_r & pb_dir_r) | ~pb_dir_r;
  assign out_port_b_drive = acr_r[7] ? {t1_pb7_r, pb_drv[6:0]} : pb_drv;
  assign out_ca2_level = cout_r[0];
  assign out_cb1_level = cout_r[1];
  assign out_cb2_level = cout_r[2];
  assign out_irq_level = ifr_r[7];

  // checks
  `CHK_ALWAYS(a_irq_sum, ifr_r[7] == |(ier_r & ifr_r[6:0]), "irq flag out of step")
  `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_read_data), "result moved")
  `CHK_ALWAYS(a_cb1_idle, out_cb1_level, "cb1 left low")
endmodule

// ===== tb/via_checker.sv =====
// request/result checker for the interface adapter: watches both channels,
// predicts every result from its own copy of the register state and compares
// depends on via_pkg
module via_checker
  import via_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [3:0] in_operation,
  input  logic [3:0] in_reg_select,
  input  logic [7:0] in_data_value,
  input  logic [7:0] in_pin_mask,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_read_data,
  input  logic [7:0] out_port_a_drive,
  input  logic [7:0] out_port_b_drive,
  input  logic       out_ca2_level,
  input  logic       out_cb1_level,
  input  logic       out_cb2_level,
  input  logic       out_irq_level,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DLY = FLAG_DELAY_DEF;
  localparam logic [2:0] LN_CA2 = 3'b001, LN_CB1 = 3'b010, LN_CB2 = 3'b100;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] pa;
    logic [7:0] pb;
    logic       ca2;
    logic       cb1;
    logic       cb2;
    logic       irq;
  } via_result_t;

  via_result_t expected_results[$];

  // shadow register state
  logic [7:0]  ora, ddra, ira_latch, pa_pins, orb, ddrb, irb_latch, pb_pins;
  logic [3:0]  ctl_in;
  logic [2:0]  ctl_out;
  logic [15:0] t1_latch, t2_latch, t2_loaded;
  int unsigned t1_cnt, t2_cnt, sr_timer;
  logic        t1_run, t1_pb7, t2_run, ca2_pulse_pending;
  logic [7:0]  sr_data, pcr, acr, ifr;
  logic [2:0]  sr_cnt;
  logic [6:0]  ier;

  function automatic void refresh_irq();
    if ((ier & ifr[6:0]) != 0) ifr[7] = 1'b1;
    else ifr[7] = 1'b0;
  endfunction

  function automatic void raise_flag(logic [7:0] f);
    ifr = ifr | f;
    refresh_irq();
  endfunction

  function automatic void drop_flag(logic [7:0] f);
    ifr = ifr & ~f;
    refresh_irq();
  endfunction

  function automatic void drive_line(logic [2:0] ln, logic lvl);
    if (lvl) ctl_out = ctl_out | ln;
    else ctl_out = ctl_out & ~ln;
  endfunction

  function automatic logic ca2_handshake_mode();
    return (pcr & 8'h0c) == 8'h08;
  endfunction

  function automatic logic ca2_pulse_mode();
    return (pcr & 8'h0e) == 8'h0a;
  endfunction

  function automatic logic cb2_handshake_mode();
    return (pcr & 8'hc0) == 8'h80;
  endfunction

  function automatic logic [4:0] shift_mode();
    return acr[4:0] & 5'h1c;
  endfunction

  function automatic int unsigned t2_shift_period();
    return (int'(t2_latch[7:0]) + 2) * 2;
  endfunction

  function automatic logic [7:0] with_pb7(logic [7:0] v);
    if (acr[7]) v[7] = t1_pb7;
    return v;
  endfunction

  function automatic logic [7:0] port_a_input();
    return pa_pins & (ora | ~ddra);
  endfunction

  function automatic logic [7:0] port_b_input();
    return with_pb7((orb & ddrb) | (pb_pins & ~ddrb));
  endfunction

  function automatic logic [15:0] t1_readback();
    if (t1_run) return 16'(t1_cnt - DLY);
    return 16'(t1_cnt);
  endfunction

  function automatic logic [15:0] t2_readback();
    if (t2_run) return 16'(t2_cnt);
    if (acr[5]) return t2_loaded;
    return 16'(t2_cnt);
  endfunction

  function automatic void clear_port_a_flags();
    drop_flag(F_CA1 | (((pcr & 8'h0a) == 8'h02) ? 8'h00 : F_CA2));
  endfunction

  function automatic void clear_port_b_flags();
    drop_flag(F_CB1 | (((pcr & 8'ha0) == 8'h20) ? 8'h00 : F_CB2));
  endfunction

  function automatic void port_a_access_handshake();
    if (ctl_out[0] && (ca2_pulse_mode() || ca2_handshake_mode())) drive_line(LN_CA2, 1'b0);
    if (ca2_pulse_mode()) ca2_pulse_pending = 1'b1;
  endfunction

  function automatic void count_one_shift();
    sr_cnt = sr_cnt + 3'd1;
    if (sr_cnt == 0) raise_flag(F_SR);
  endfunction

  function automatic void shift_bit_out();
    logic b;
    b = sr_data[7];
    drive_line(LN_CB2, b);
    sr_data = {sr_data[6:0], b};
    if (shift_mode() != SR_OUT_FREE) count_one_shift();
  endfunction

  function automatic void shift_bit_in();
    sr_data = {sr_data[6:0], ctl_in[3]};
    count_one_shift();
  endfunction

  function automatic void shift_clock_pulse();
    logic [4:0] m;
    m = shift_mode();
    drive_line(LN_CB1, 1'b0);
    if (m == SR_OUT_FREE || m == SR_OUT_T2 || m == SR_OUT_PHI) shift_bit_out();
    drive_line(LN_CB1, 1'b1);
    if (m == SR_IN_T2 || m == SR_IN_PHI) shift_bit_in();
    if (m == SR_OUT_FREE || sr_cnt != 0) begin
      if (m == SR_IN_PHI || m == SR_OUT_PHI) sr_timer = 2;
      else sr_timer = t2_shift_period();
    end
  endfunction

  // one bus clock of timers, shifter and ca2 pulse
  function automatic void advance_clock();
    if (t1_run) begin
      if (t1_cnt <= 1) begin
        if (acr[6]) begin
          t1_pb7 = ~t1_pb7;
          t1_cnt = t1_latch + DLY;
        end else begin
          t1_pb7 = 1'b1;
          t1_run = 1'b0;
          t1_cnt = 32'hffff;
        end
        raise_flag(F_T1);
      end else t1_cnt--;
    end else t1_cnt = (t1_cnt - 1) & 32'hffff;
    if (t2_run) begin
      if (t2_cnt <= 1) begin
        t2_run = 1'b0;
        t2_cnt = 32'hffff;
        raise_flag(F_T2);
      end else t2_cnt--;
    end else t2_cnt = (t2_cnt - 1) & 32'hffff;
    if (sr_timer != 0) begin
      sr_timer--;
      if (sr_timer == 0) shift_clock_pulse();
    end
    if (ca2_pulse_pending) begin
      ca2_pulse_pending = 1'b0;
      drive_line(LN_CA2, 1'b1);
    end
  endfunction

  function automatic logic [7:0] register_read(via_reg_t r);
    logic [7:0] v;
    logic [15:0] c;
    v = 8'h00;
    case (r)
      R_ORB: begin
        v = acr[1] ? irb_latch : port_b_input();
        clear_port_b_flags();
      end
      R_ORA: begin
        v = acr[0] ? ira_latch : port_a_input();
        clear_port_a_flags();
        port_a_access_handshake();
      end
      R_DDRB: v = ddrb;
      R_DDRA: v = ddra;
      R_T1CL: begin
        drop_flag(F_T1);
        c = t1_readback();
        v = c[7:0];
      end
      R_T1CH: begin
        c = t1_readback();
        v = c[15:8];
      end
      R_T1LL: v = t1_latch[7:0];
      R_T1LH: v = t1_latch[15:8];
      R_T2CL: begin
        drop_flag(F_T2);
        c = t2_readback();
        v = c[7:0];
      end
      R_T2CH: begin
        c = t2_readback();
        v = c[15:8];
      end
      R_SR: begin
        v = sr_data;
        sr_cnt = 0;
        drop_flag(F_SR);
        if (shift_mode() == SR_IN_PHI) sr_timer = 2;
        if (shift_mode() == SR_IN_T2) sr_timer = t2_shift_period();
      end
      R_ACR: v = acr;
      R_PCR: v = pcr;
      R_IFR: v = ifr;
      R_IER: v = {1'b1, ier};
      default: v = acr[0] ? ira_latch : port_a_input();
    endcase
    return v;
  endfunction

  function automatic void register_write(via_reg_t r, logic [7:0] d);
    logic [15:0] c;
    case (r)
      R_ORB: begin
        orb = d;
        clear_port_b_flags();
        if (ctl_out[2] && cb2_handshake_mode()) drive_line(LN_CB2, 1'b0);
      end
      R_ORA: begin
        ora = d;
        clear_port_a_flags();
        port_a_access_handshake();
      end
      R_DDRB: ddrb = d;
      R_DDRA: ddra = d;
      R_T1CL, R_T1LL: t1_latch[7:0] = d;
      R_T1LH: begin
        t1_latch[15:8] = d;
        drop_flag(F_T1);
      end
      R_T1CH: begin
        t1_latch[15:8] = d;
        drop_flag(F_T1);
        t1_pb7 = 1'b0;
        t1_cnt = t1_latch + DLY;
        t1_run = 1'b1;
      end
      R_T2CL: t2_latch[7:0] = d;
      R_T2CH: begin
        t2_latch[15:8] = d;
        t2_loaded = t2_latch;
        drop_flag(F_T2);
        if (acr[5]) t2_cnt = t2_latch;
        else t2_cnt = t2_latch + DLY;
        t2_run = 1'b1;
      end
      R_SR: begin
        sr_data = d;
        sr_cnt = 0;
        drop_flag(F_SR);
        if (shift_mode() == SR_OUT_PHI) sr_timer = 2;
        if (shift_mode() == SR_OUT_FREE || shift_mode() == SR_OUT_T2)
          sr_timer = t2_shift_period();
      end
      R_ACR: begin
        c = t1_readback();
        acr = d;
        if (d[6]) begin
          t1_cnt = c + DLY;
          t1_run = 1'b1;
        end
      end
      R_PCR: begin
        pcr = d;
        if ((d & 8'h0c) == 8'h0c) drive_line(LN_CA2, d[1]);
        if ((d & 8'hc0) == 8'hc0) drive_line(LN_CB2, d[5]);
      end
      R_IFR: drop_flag(d[7] ? 8'h7f : d);
      R_IER: begin
        if (d[7]) ier = ier | d[6:0];
        else ier = ier & ~d[6:0];
        refresh_irq();
      end
      default: ora = d;
    endcase
  endfunction

  // level change on one of CA1, CA2, CB1, CB2
  function automatic void control_line_change(int line, logic lvl);
    if (ctl_in[line] == lvl) return;
    ctl_in[line] = lvl;
    case (line)
      0: if (lvl == pcr[0]) begin
        if (acr[0]) ira_latch = port_a_input();
        raise_flag(F_CA1);
        if (!ctl_out[0] && ca2_handshake_mode()) drive_line(LN_CA2, 1'b1);
      end
      1: if (!pcr[3] && lvl == pcr[2]) raise_flag(F_CA2);
      2: if (lvl == pcr[4]) begin
        if (acr[1]) irb_latch = port_b_input();
        if (shift_mode() == SR_OUT_CB1) shift_bit_out();
        if (shift_mode() == SR_IN_CB1) shift_bit_in();
        raise_flag(F_CB1);
        if (!ctl_out[2] && cb2_handshake_mode()) drive_line(LN_CB2, 1'b1);
      end
      default: if (!pcr[7] && lvl == pcr[6]) raise_flag(F_CB2);
    endcase
  endfunction

  function automatic via_result_t apply_request(logic [3:0] op, logic [3:0] rs,
                                                logic [7:0] d, logic [7:0] m);
    via_result_t res;
    res.rd = 8'h00;
    case (op)
      OP_READ:  res.rd = register_read(via_reg_t'(rs));
      OP_WRITE: register_write(via_reg_t'(rs), d);
      OP_PA:    pa_pins = (pa_pins & ~m) | (d & m);
      OP_PB:    pb_pins = (pb_pins & ~m) | (d & m);
      OP_CA1, OP_CA2, OP_CB1, OP_CB2: control_line_change(int'(op) - 4, (d & m) != 0);
      OP_TICK:  advance_clock();
      default: ;
    endcase
    res.pa  = (ora & ddra) | ~ddra;
    res.pb  = with_pb7((orb & ddrb) | ~ddrb);
    res.ca2 = ctl_out[0];
    res.cb1 = ctl_out[1];
    res.cb2 = ctl_out[2];
    res.irq = ifr[7];
    return res;
  endfunction

  function automatic void clear_shadow();
    ora = 0; ddra = 0; ira_latch = 0; pa_pins = 0;
    orb = 0; ddrb = 0; irb_latch = 0; pb_pins = 0;
    ctl_in = 0; ctl_out = 3'b111;
    t1_latch = T1_LATCH_RST; t1_cnt = 0; t1_run = 0; t1_pb7 = 1;
    t2_latch = T2_LATCH_RST; t2_cnt = 0; t2_run = 0; t2_loaded = 0;
    sr_data = 0; sr_cnt = 0; sr_timer = 0; ca2_pulse_pending = 0;
    pcr = 0; acr = 0; ier = 0; ifr = 0;
  endfunction

  function automatic void compare_field(string nm, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $realtime, nm, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // results are popped before the request of the same edge is pushed
  always @(posedge clk) begin
    via_result_t exp_r;
    if (!rst_n) begin
      clear_shadow();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting, read_data %02h", $realtime,
                   out_read_data);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("read_data", exp_r.rd, out_read_data);
          compare_field("port_a_drive", exp_r.pa, out_port_a_drive);
          compare_field("port_b_drive", exp_r.pb, out_port_b_drive);
          compare_field("ca2_level", exp_r.ca2, out_ca2_level);
          compare_field("cb1_level", exp_r.cb1, out_cb1_level);
          compare_field("cb2_level", exp_r.cb2, out_cb2_level);
          compare_field("irq_level", exp_r.irq, out_irq_level);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(in_operation, in_reg_select,
                                                 in_data_value, in_pin_mask));
    end
    pending = expected_results.size();
  end
endmodule

// ===== tb/tb_top.sv =====
// testbench top for the interface adapter: clock, reset, request stimulus,
// receiver stalls and the verdict; depends on via_pkg and via_checker
module tb_top
  import via_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  logic [3:0] in_operation, in_reg_select;
  logic [7:0] in_data_value, in_pin_mask;
  logic [7:0] out_read_data, out_port_a_drive, out_port_b_drive;
  logic       out_ca2_level, out_cb1_level, out_cb2_level, out_irq_level;
  int         fail_count, pending, cycles;
  int         idle_pct, stall_pct;
  bit         hold_req;

  versatile_interface_adapter_unit u_top (.*);

  via_checker u_checker (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one request, held until accepted; random gap before it
  task automatic send_request(via_op_t op, via_reg_t rs, logic [7:0] d, logic [7:0] m);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_reg_select <= rs;
    in_data_value <= d;
    in_pin_mask <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_raw(logic [3:0] op, logic [3:0] rs, logic [7:0] d, logic [7:0] m);
    send_request(via_op_t'(op), via_reg_t'(rs), d, m);
  endtask

  // random request mix, weighted toward ticks and timer starts so timers fire
  task automatic send_random_request();
    int k;
    logic [3:0] rs;
    logic [7:0] d;
    k = $urandom_range(0, 99);
    rs = 4'($urandom_range(0, 15));
    d = 8'($urandom);
    if (k < 40) send_request(OP_TICK, via_reg_t'(rs), d, 8'($urandom));
    else if (k < 62) begin
      if ((rs == R_T1CH || rs == R_T2CH) && $urandom_range(0, 3) != 0)
        d = 8'($urandom_range(0, 1));
      if ((rs == R_T1CL || rs == R_T2CL) && $urandom_range(0, 1) != 0)
        d = 8'($urandom_range(0, 12));
      send_request(OP_WRITE, via_reg_t'(rs), d, 8'($urandom));
    end else if (k < 76) send_request(OP_READ, via_reg_t'(rs), d, 8'($urandom));
    else if (k < 82)
      send_raw(4'($urandom_range(OP_PA, OP_PB)), rs, d, 8'($urandom));
    else if (k < 96) begin
      if ($urandom_range(0, 3) != 0)
        send_raw(4'($urandom_range(OP_CA1, OP_CB2)), rs, 8'($urandom_range(0, 1)), 8'h01);
      else send_raw(4'($urandom_range(OP_CA1, OP_CB2)), rs, d, 8'($urandom));
    end else send_raw(4'($urandom_range(9, 15)), rs, d, 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_reg_select = '0;
    in_data_value = '0;
    in_pin_mask = '0;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, zero period, continuous mode, shifter, ports
    send_request(OP_READ, R_T1LH, 8'h00, 8'h00);
    send_request(OP_WRITE, R_IER, 8'hff, 8'h00);
    send_request(OP_WRITE, R_T1CL, 8'h00, 8'h00);
    send_request(OP_WRITE, R_T1CH, 8'h00, 8'h00);
    send_request(OP_TICK, R_ORB, 8'h00, 8'h00);
    send_request(OP_TICK, R_ORB, 8'h00, 8'h00);
    send_request(OP_READ, R_T1CL, 8'h00, 8'h00);
    send_request(OP_WRITE, R_ACR, 8'hdf, 8'h00);
    send_request(OP_TICK, R_ORB, 8'hff, 8'hff);
    send_request(OP_WRITE, R_IFR, 8'h80, 8'h00);
    send_request(OP_WRITE, R_ACR, 8'h18, 8'h00);
    send_request(OP_WRITE, R_SR, 8'haa, 8'h00);
    repeat (4) send_request(OP_TICK, R_ORB, 8'h00, 8'h00);
    send_request(OP_WRITE, R_DDRA, 8'hff, 8'h00);
    send_request(OP_WRITE, R_ORA_NH, 8'h5a, 8'h00);
    send_request(OP_READ, R_ORA_NH, 8'h00, 8'h00);
    send_request(OP_WRITE, R_PCR, 8'hee, 8'h00);
    send_request(OP_PA, R_ORB, 8'hff, 8'hff);
    send_request(OP_CB1, R_ORB, 8'hff, 8'hff);
    send_request(OP_CA1, R_ORB, 8'h01, 8'h01);
    send_raw(4'd15, 4'd15, 8'hff, 8'hff);
    send_request(OP_READ, R_IFR, 8'h00, 8'h00);

    // random phases with different idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 53; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 53; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (ph == 1) wait_drained();
      for (int i = 0; i < 490; i++) begin
        if (ph == 0 && i == 100) hold_req = 1'b1;
        send_random_request();
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/via_pkg.sv
sv/versatile_interface_adapter_unit.sv
tb/via_checker.sv
tb/tb_top.sv
